@@ rtl/core/iiee_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iiee_pkg
// Shared types, codes and helper functions of the infix expression evaluator.
// ----------------------------------------------------------------------------
package iiee_pkg;

    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_ADD    = 4'd1,
        OP_SUB    = 4'd2,
        OP_MUL    = 4'd3,
        OP_DIV    = 4'd4,
        OP_AND    = 4'd5,
        OP_OR     = 4'd6,
        OP_XOR    = 4'd7,
        OP_SHL    = 4'd8,
        OP_SHR    = 4'd9,
        OP_LPAREN = 4'd10
    } t_op;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_DEC  = 2'd1,
        MODE_HEX  = 2'd2,
        MODE_BIN  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        TK_VAL  = 3'd0,
        TK_OP   = 3'd1,
        TK_LPAR = 3'd2,
        TK_RPAR = 3'd3,
        TK_END  = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        t_op         op;
        logic [31:0] val;
    } t_token;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DIVZ    = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    localparam int QDEPTH = 4;

    // Only the first error of an expression is kept.
    function automatic logic [1:0] raise(logic [1:0] err, logic [1:0] code);
        return (err == ST_OK) ? code : err;
    endfunction

    function automatic logic [1:0] level(t_op op);
        logic [1:0] l;
        case (op)
            OP_ADD, OP_SUB:                         l = 2'd1;
            OP_MUL, OP_DIV:                         l = 2'd2;
            OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR:  l = 2'd3;
            default:                                l = 2'd0;
        endcase
        return l;
    endfunction

    // Returns {valid, digit value}.
    function automatic logic [4:0] digit_of(t_mode m, logic [7:0] c);
        logic [4:0] d;
        d = 5'd0;
        if (c >= "0" && c <= "9") begin
            if (m != MODE_BIN || c <= "1") d = {1'b1, 4'(c - "0")};
        end else if (m == MODE_HEX) begin
            if (c >= "a" && c <= "f") d = {1'b1, 4'(c - "a" + 8'd10)};
            if (c >= "A" && c <= "F") d = {1'b1, 4'(c - "A" + 8'd10)};
        end
        return d;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/iiee_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iiee_front
// Lexer: one character of lookahead, literal forming, token issue.
// ----------------------------------------------------------------------------
module iiee_front import iiee_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [7:0]  i_character,
    input  wire logic        i_end_of_expression,
    output logic             o_push,
    output t_token           o_token,
    input  wire logic        i_full
);

    typedef enum logic [3:0] {
        F_IDLE  = 4'b0001,
        F_CALL1 = 4'b0010,
        F_CALL2 = 4'b0100,
        F_FIN   = 4'b1000
    } t_fstate;

    t_fstate     r_state, n_state;
    logic [7:0]  r_c, r_pend_c;
    logic        r_last, r_pend_v, r_used, r_called;
    t_mode       r_lit, r_armed;
    logic [31:0] r_acc;
    logic        r_neg, r_dig;
    logic        r_bv, r_bo;
    logic [31:0] r_bval;
    t_kind       r_bkind;
    t_op         r_bop;

    logic [7:0]  pc, pnx;
    t_mode       p_mode, p_lit, p_armed;
    logic [31:0] p_acc, fin_val, acc_base;
    logic        p_neg, p_dig, p_used, p_tv, p_to;
    t_kind       p_kind;
    t_op         p_op;
    logic [4:0]  dl, dm, dn;

    assign busy = (r_state != F_IDLE);
    assign pc   = (r_state == F_CALL1) ? r_pend_c : r_c;
    assign pnx  = (r_state == F_CALL1) ? r_c : " ";
    assign fin_val = r_neg ? (32'd0 - r_acc) : r_acc;

    always_comb begin
        case (r_lit)
            MODE_HEX: acc_base = {r_acc[27:0], 4'd0};
            MODE_BIN: acc_base = {r_acc[30:0], 1'b0};
            default:  acc_base = {r_acc[28:0], 3'd0} + {r_acc[30:0], 1'b0};
        endcase
    end

    always_comb begin
        p_mode  = (r_armed != MODE_NONE) ? r_armed : MODE_DEC;
        p_lit   = r_lit;
        p_acc   = r_acc;
        p_neg   = r_neg;
        p_dig   = r_dig;
        p_armed = MODE_NONE;
        p_used  = 1'b0;
        p_tv    = 1'b0;
        p_to    = 1'b0;
        p_kind  = TK_OP;
        p_op    = OP_NONE;
        dl = digit_of(r_lit, pc);
        dm = digit_of(p_mode, pc);
        dn = digit_of(p_mode, pnx);
        if (pc == "0" && (pnx == "x" || pnx == "b")) begin
            p_used  = 1'b1;
            p_armed = (pnx == "x") ? MODE_HEX : MODE_BIN;
            // A lone minus sign before a radix prefix is a subtraction.
            if (r_lit != MODE_NONE && !r_dig) begin
                p_to = 1'b1;
                p_op = OP_SUB;
            end else if (r_lit != MODE_NONE) begin
                p_tv = 1'b1;
            end
            p_lit = MODE_NONE;
            p_acc = 32'd0;
            p_neg = 1'b0;
            p_dig = 1'b0;
        end else if ((pc == "<" && pnx == "<") || (pc == ">" && pnx == ">")) begin
            p_used = 1'b1;
            p_tv   = (r_lit != MODE_NONE);
            p_lit  = MODE_NONE;
            p_acc  = 32'd0;
            p_neg  = 1'b0;
            p_dig  = 1'b0;
            p_to   = 1'b1;
            p_op   = (pc == "<") ? OP_SHL : OP_SHR;
        end else if (r_lit != MODE_NONE && dl[4]) begin
            p_acc = acc_base + {28'd0, dl[3:0]};
            p_dig = 1'b1;
        end else begin
            p_tv  = (r_lit != MODE_NONE);
            p_lit = MODE_NONE;
            p_acc = 32'd0;
            p_neg = 1'b0;
            p_dig = 1'b0;
            if (dm[4]) begin
                p_lit = p_mode;
                p_acc = {28'd0, dm[3:0]};
                p_dig = 1'b1;
            end else begin
                case (pc)
                    "-": begin
                        if (dn[4]) begin
                            p_lit = p_mode;
                            p_neg = 1'b1;
                        end else begin
                            p_to = 1'b1;
                            p_op = OP_SUB;
                        end
                    end
                    "+": begin p_to = 1'b1; p_op = OP_ADD; end
                    "*": begin p_to = 1'b1; p_op = OP_MUL; end
                    "/": begin p_to = 1'b1; p_op = OP_DIV; end
                    "&": begin p_to = 1'b1; p_op = OP_AND; end
                    "|": begin p_to = 1'b1; p_op = OP_OR;  end
                    "^": begin p_to = 1'b1; p_op = OP_XOR; end
                    "(": begin p_to = 1'b1; p_kind = TK_LPAR; end
                    ")": begin p_to = 1'b1; p_kind = TK_RPAR; end
                    default: ;
                endcase
            end
        end
    end

    assign o_push  = (r_state != F_IDLE) && r_called && (r_bv || r_bo) && !i_full;
    assign o_token = r_bv ? t_token'{kind: TK_VAL, op: OP_NONE, val: r_bval}
                          : t_token'{kind: r_bkind, op: r_bop, val: 32'd0};

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (start) n_state = F_CALL1;
            F_CALL1: if (r_called && !r_bv && !r_bo) n_state = F_CALL2;
            F_CALL2: if (r_called && !r_bv && !r_bo) n_state = F_FIN;
            F_FIN:   if (r_called && !r_bv && !r_bo) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_IDLE;
            r_pend_v <= 1'b0;
            r_called <= 1'b0;
            r_used   <= 1'b0;
            r_lit    <= MODE_NONE;
            r_armed  <= MODE_NONE;
            r_acc    <= 32'd0;
            r_neg    <= 1'b0;
            r_dig    <= 1'b0;
            r_bv     <= 1'b0;
            r_bo     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == F_IDLE) begin
                if (start) begin
                    r_c      <= i_character;
                    r_last   <= i_end_of_expression;
                    r_called <= 1'b0;
                end
            end else if (!r_called) begin
                r_called <= 1'b1;
                if (r_state == F_FIN) begin
                    if (r_last) begin
                        r_bv    <= (r_lit != MODE_NONE);
                        r_bval  <= fin_val;
                        r_bo    <= 1'b1;
                        r_bkind <= TK_END;
                        r_bop   <= OP_NONE;
                        r_lit   <= MODE_NONE;
                        r_acc   <= 32'd0;
                        r_neg   <= 1'b0;
                        r_dig   <= 1'b0;
                        r_armed <= MODE_NONE;
                    end
                end else if ((r_state == F_CALL1 && r_pend_v) ||
                             (r_state == F_CALL2 && !r_used && r_last)) begin
                    r_lit   <= p_lit;
                    r_acc   <= p_acc;
                    r_neg   <= p_neg;
                    r_dig   <= p_dig;
                    r_armed <= p_armed;
                    r_bv    <= p_tv;
                    r_bval  <= fin_val;
                    r_bo    <= p_to;
                    r_bkind <= p_kind;
                    r_bop   <= p_op;
                    if (r_state == F_CALL1) r_used <= p_used;
                end else if (r_state == F_CALL1) begin
                    r_used <= 1'b0;
                end else if (!r_used) begin
                    r_pend_c <= r_c;
                end
                if (r_state == F_CALL1) r_pend_v <= 1'b0;
                if (r_state == F_CALL2) r_pend_v <= !r_used && !r_last;
            end else if (r_bv || r_bo) begin
                if (!i_full) begin
                    if (r_bv) r_bv <= 1'b0;
                    else      r_bo <= 1'b0;
                end
            end else begin
                r_called <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/iiee_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iiee_queue
// Short token queue between the lexer and the stack engine.
// ----------------------------------------------------------------------------
module iiee_queue import iiee_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_token i_data,
    input  wire logic   i_pop,
    output t_token      o_data,
    output logic        o_empty,
    output logic        o_full
);

    localparam int PW = $clog2(QDEPTH);

    t_token          r_mem [QDEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (PW+1)'(QDEPTH));
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wp <= r_wp + 1'b1;
            if (i_pop && !o_empty) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(i_push && !o_full) - (PW+1)'(i_pop && !o_empty);
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/iiee_alu.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iiee_alu
// 64-bit operation unit: registered add, shift and logic ops, three-step multiply, serial divide.
// ----------------------------------------------------------------------------
module iiee_alu import iiee_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire t_op         i_op,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic             o_done,
    output logic [63:0]      o_res,
    output logic             o_dz
);

    typedef enum logic [2:0] {
        A_IDLE = 3'b001,
        A_MUL  = 3'b010,
        A_DIV  = 3'b100
    } t_astate;

    t_astate     r_state;
    logic [63:0] r_a, r_b, r_p, r_quo, r_rem, r_dvs;
    logic [31:0] r_x;
    logic [1:0]  r_step;
    logic [5:0]  r_cnt;
    logic        r_neg;

    logic [31:0] m_l, m_r;
    logic [63:0] m_p, q_next;
    logic [64:0] rem_sh, rem_df;
    logic [5:0]  sh;
    logic        qbit;

    assign sh = i_b[5:0];

    always_comb begin
        case (r_step)
            2'd0:    begin m_l = r_a[31:0];  m_r = r_b[31:0];  end
            2'd1:    begin m_l = r_a[31:0];  m_r = r_b[63:32]; end
            default: begin m_l = r_a[63:32]; m_r = r_b[31:0];  end
        endcase
        m_p = m_l * m_r;
    end

    assign rem_sh = {r_rem, r_quo[63]};
    assign rem_df = rem_sh - {1'b0, r_dvs};
    assign qbit   = !rem_df[64];
    assign q_next = {r_quo[62:0], qbit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            o_done  <= 1'b0;
            o_dz    <= 1'b0;
        end else begin
            o_done <= 1'b0;
            o_dz   <= 1'b0;
            case (r_state)
                A_IDLE: begin
                    if (i_start) begin
                        r_a    <= i_a;
                        r_b    <= i_b;
                        r_step <= 2'd0;
                        case (i_op)
                            OP_ADD: begin o_res <= i_a + i_b; o_done <= 1'b1; end
                            OP_SUB: begin o_res <= i_a - i_b; o_done <= 1'b1; end
                            OP_AND: begin o_res <= i_a & i_b; o_done <= 1'b1; end
                            OP_OR:  begin o_res <= i_a | i_b; o_done <= 1'b1; end
                            OP_XOR: begin o_res <= i_a ^ i_b; o_done <= 1'b1; end
                            OP_SHL: begin o_res <= i_a << sh; o_done <= 1'b1; end
                            OP_SHR: begin
                                o_res  <= 64'($signed(i_a) >>> sh);
                                o_done <= 1'b1;
                            end
                            OP_MUL: r_state <= A_MUL;
                            OP_DIV: begin
                                if (i_b == 64'd0) begin
                                    o_res  <= 64'd0;
                                    o_dz   <= 1'b1;
                                    o_done <= 1'b1;
                                end else begin
                                    r_quo   <= i_a[63] ? (64'd0 - i_a) : i_a;
                                    r_dvs   <= i_b[63] ? (64'd0 - i_b) : i_b;
                                    r_rem   <= 64'd0;
                                    r_neg   <= i_a[63] ^ i_b[63];
                                    r_cnt   <= 6'd63;
                                    r_state <= A_DIV;
                                end
                            end
                            default: begin o_res <= 64'd0; o_done <= 1'b1; end
                        endcase
                    end
                end
                A_MUL: begin
                    r_step <= r_step + 2'd1;
                    case (r_step)
                        2'd0: r_p <= m_p;
                        2'd1: r_x <= m_p[31:0];
                        default: begin
                            o_res   <= r_p + {r_x + m_p[31:0], 32'd0};
                            o_done  <= 1'b1;
                            r_state <= A_IDLE;
                        end
                    endcase
                end
                A_DIV: begin
                    r_quo <= q_next;
                    r_rem <= qbit ? rem_df[63:0] : rem_sh[63:0];
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        o_res   <= r_neg ? (64'd0 - q_next) : q_next;
                        o_done  <= 1'b1;
                        r_state <= A_IDLE;
                    end
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/iiee_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iiee_back
// Stack engine: value and operator stacks, operator precedence, result issue.
// ----------------------------------------------------------------------------
module iiee_back import iiee_pkg::*; #(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_token      i_token,
    input  wire logic        i_empty,
    output logic             o_pop,
    output logic             o_strobe,
    output logic [63:0]      o_value,
    output logic [1:0]       o_status
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [7:0] {
        B_IDLE  = 8'b0000_0001,
        B_LOOP  = 8'b0000_0010,
        B_OPCHK = 8'b0000_0100,
        B_POPB  = 8'b0000_1000,
        B_POPA  = 8'b0001_0000,
        B_CALC  = 8'b0010_0000,
        B_WAIT  = 8'b0100_0000,
        B_FIN   = 8'b1000_0000
    } t_bstate;

    logic [63:0] r_vmem [STACK_DEPTH];
    t_op         r_omem [STACK_DEPTH];

    t_bstate     r_state, n_state;
    logic [CW-1:0] r_vtop, n_vtop, r_otop, n_otop;
    logic [1:0]  r_err, n_err;
    t_token      r_tok, n_tok;
    t_op         r_op, n_op;
    logic        r_av, n_av, r_bv, n_bv;
    logic [63:0] r_b, n_b, r_vrd;
    t_op         r_ord;

    logic        v_we, o_we, alu_start, alu_done, alu_dz, apply, vfull, ofull;
    logic [AW-1:0] v_ra, o_ra;
    logic [63:0] v_wd, alu_a, alu_res;
    t_op         o_wd;
    logic [1:0]  e1;

    assign v_ra  = AW'(r_vtop - 1'b1);
    assign o_ra  = AW'(r_otop - 1'b1);
    assign vfull = (r_vtop == CW'(STACK_DEPTH));
    assign ofull = (r_otop == CW'(STACK_DEPTH));
    assign alu_a = r_av ? r_vrd : 64'd0;

    iiee_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (alu_start),
        .i_op    (r_op),
        .i_a     (alu_a),
        .i_b     (r_b),
        .o_done  (alu_done),
        .o_res   (alu_res),
        .o_dz    (alu_dz)
    );

    always_comb begin
        case (r_tok.kind)
            TK_OP:   apply = (level(r_ord) >= level(r_tok.op));
            default: apply = (r_ord != OP_LPAREN);
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_vtop  = r_vtop;
        n_otop  = r_otop;
        n_err   = r_err;
        n_tok   = r_tok;
        n_op    = r_op;
        n_av    = r_av;
        n_bv    = r_bv;
        n_b     = r_b;
        v_we    = 1'b0;
        v_wd    = {{32{i_token.val[31]}}, i_token.val};
        o_we    = 1'b0;
        o_wd    = r_tok.op;
        o_pop   = 1'b0;
        alu_start = 1'b0;
        e1      = r_err;
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_tok = i_token;
                    case (i_token.kind)
                        TK_VAL: begin
                            if (vfull) n_err = raise(r_err, ST_FULL);
                            else begin v_we = 1'b1; n_vtop = r_vtop + 1'b1; end
                        end
                        TK_LPAR: begin
                            o_wd = OP_LPAREN;
                            if (ofull) n_err = raise(r_err, ST_FULL);
                            else begin o_we = 1'b1; n_otop = r_otop + 1'b1; end
                        end
                        default: n_state = B_LOOP;
                    endcase
                end
            end
            B_LOOP: begin
                if (r_otop == '0) begin
                    n_state = B_IDLE;
                    case (r_tok.kind)
                        TK_OP: begin
                            if (ofull) n_err = raise(r_err, ST_FULL);
                            else begin o_we = 1'b1; n_otop = r_otop + 1'b1; end
                        end
                        TK_END: begin
                            n_state = B_FIN;
                            n_av    = (r_vtop != '0);
                            if (r_vtop == '0) n_err = raise(r_err, ST_MISSING);
                        end
                        default: ;
                    endcase
                end else begin
                    n_state = B_OPCHK;
                end
            end
            B_OPCHK: begin
                if (apply) begin
                    n_op    = r_ord;
                    n_otop  = r_otop - 1'b1;
                    n_state = B_POPB;
                end else begin
                    n_state = B_IDLE;
                    case (r_tok.kind)
                        TK_OP: begin
                            if (ofull) n_err = raise(r_err, ST_FULL);
                            else begin o_we = 1'b1; n_otop = r_otop + 1'b1; end
                        end
                        TK_END: begin
                            n_otop  = r_otop - 1'b1;
                            n_state = B_LOOP;
                        end
                        default: n_otop = r_otop - 1'b1;
                    endcase
                end
            end
            B_POPB: begin
                n_bv = (r_vtop != '0);
                if (r_vtop != '0) n_vtop = r_vtop - 1'b1;
                else n_err = raise(r_err, ST_MISSING);
                n_state = B_POPA;
            end
            B_POPA: begin
                n_b  = r_bv ? r_vrd : 64'd0;
                n_av = (r_vtop != '0);
                if (r_vtop != '0) n_vtop = r_vtop - 1'b1;
                else n_err = raise(r_err, ST_MISSING);
                n_state = B_CALC;
            end
            B_CALC: begin
                alu_start = 1'b1;
                n_state   = B_WAIT;
            end
            B_WAIT: begin
                if (alu_done) begin
                    e1   = alu_dz ? raise(r_err, ST_DIVZ) : r_err;
                    v_wd = alu_res;
                    if (vfull) n_err = raise(e1, ST_FULL);
                    else begin
                        n_err  = e1;
                        v_we   = 1'b1;
                        n_vtop = r_vtop + 1'b1;
                    end
                    n_state = B_LOOP;
                end
            end
            B_FIN: begin
                n_vtop  = '0;
                n_otop  = '0;
                n_err   = ST_OK;
                n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (v_we) r_vmem[r_vtop[AW-1:0]] <= v_wd;
        r_vrd <= r_vmem[v_ra];
    end

    always_ff @(posedge i_clk) begin
        if (o_we) r_omem[r_otop[AW-1:0]] <= o_wd;
        r_ord <= r_omem[o_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_vtop   <= '0;
            r_otop   <= '0;
            r_err    <= ST_OK;
            o_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_vtop   <= n_vtop;
            r_otop   <= n_otop;
            r_err    <= n_err;
            o_strobe <= (r_state == B_FIN);
        end
        r_tok <= n_tok;
        r_op  <= n_op;
        r_av  <= n_av;
        r_bv  <= n_bv;
        r_b   <= n_b;
        if (r_state == B_FIN) begin
            o_value  <= r_av ? r_vrd : 64'd0;
            o_status <= r_err;
        end
    end

    a_vtop_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vtop <= CW'(STACK_DEPTH)) else $error("value stack count out of range");
    a_otop_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_otop <= CW'(STACK_DEPTH)) else $error("operator stack count out of range");
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == B_FIN)) else $error("result without drain");
    a_clean_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (r_vtop == '0 && r_otop == '0 && r_err == ST_OK))
        else $error("state not cleared after result");
    a_alu_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_done |-> r_state == B_WAIT) else $error("operation finished unexpectedly");

endmodule
`default_nettype wire

@@ rtl/core/infix_integer_expression_evaluator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// infix_integer_expression_evaluator
// Evaluates an infix integer expression fed one character per request.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  input     i_character, i_end_of_expression        start & !busy
//  result    o_value, o_status                       o_strobe, one cycle
//
//  The lexer steps through its call states for each character and issues
//  each token it forms; busy is high meanwhile and while the token queue is full.
//  The stack engine runs on its own: multiply forms three 32x32 partial
//  products and divide yields one quotient bit per cycle; a closing
//  bracket or the last character drains.
//  Reset is synchronous and active low; stack contents need no clearing.
//  The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module infix_integer_expression_evaluator import iiee_pkg::*; #(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [7:0]  i_character,
    input  wire logic        i_end_of_expression,
    output logic             o_strobe,
    output logic [63:0]      o_value,
    output logic [1:0]       o_status
);

    t_token q_in, q_out;
    logic   q_push, q_pop, q_empty, q_full;

    iiee_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_character         (i_character),
        .i_end_of_expression (i_end_of_expression),
        .o_push              (q_push),
        .o_token             (q_in),
        .i_full              (q_full)
    );

    iiee_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    iiee_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_token  (q_out),
        .i_empty  (q_empty),
        .o_pop    (q_pop),
        .o_strobe (o_strobe),
        .o_value  (o_value),
        .o_status (o_status)
    );

endmodule
`default_nettype wire

@@ sim/infix_integer_expression_evaluator_checker.sv @@
// ----------------------------------------------------------------------------
// infix_integer_expression_evaluator_checker
// Watches the request and result channels of the expression evaluator. It
// keeps its own shunting-yard model of the block, works out the value and
// status for every completed expression and compares them with the results.
// ----------------------------------------------------------------------------
module infix_integer_expression_evaluator_checker import iiee_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [7:0]  i_character,
    input  wire logic        i_end_of_expression,
    input  wire logic        o_strobe,
    input  wire logic [63:0] o_value,
    input  wire logic [1:0]  o_status,
    output int               o_failures,
    output int               o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;

    typedef struct {
        logic [63:0] value;
        logic [1:0]  status;
    } t_answer;

    t_answer     answers_due[$];

    logic [63:0] vals[DEPTH];
    t_op         ops[DEPTH];
    int          nvals;
    int          nops;
    logic [31:0] lit_acc;
    t_mode       lit_mode;
    bit          lit_neg;
    bit          lit_digits;
    t_mode       armed;
    bit          held_valid;
    logic [7:0]  held_char;
    logic [1:0]  err;

    function automatic void clear_model();
        nvals = 0;
        nops = 0;
        lit_acc = '0;
        lit_mode = MODE_NONE;
        lit_neg = 0;
        lit_digits = 0;
        armed = MODE_NONE;
        held_valid = 0;
        held_char = '0;
        err = ST_OK;
    endfunction

    function automatic void note_error(logic [1:0] code);
        if (err == ST_OK) err = code;
    endfunction

    function automatic void push_val(logic [63:0] v);
        if (nvals >= DEPTH) note_error(ST_FULL);
        else begin
            vals[nvals] = v;
            nvals++;
        end
    endfunction

    function automatic logic [63:0] pop_val();
        if (nvals == 0) begin
            note_error(ST_MISSING);
            return '0;
        end
        nvals--;
        return vals[nvals];
    endfunction

    function automatic void push_op(t_op op);
        if (nops >= DEPTH) note_error(ST_FULL);
        else begin
            ops[nops] = op;
            nops++;
        end
    endfunction

    function automatic int binding(t_op op);
        case (op)
            OP_ADD, OP_SUB: return 1;
            OP_MUL, OP_DIV: return 2;
            OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR: return 3;
            default: return 0;
        endcase
    endfunction

    function automatic logic [63:0] arith(logic [63:0] a, logic [63:0] b, t_op op);
        logic [63:0] ma, mb, q;
        case (op)
            OP_ADD: return a + b;
            OP_SUB: return a - b;
            OP_MUL: return a * b;
            OP_AND: return a & b;
            OP_OR:  return a | b;
            OP_XOR: return a ^ b;
            OP_SHL: return a << b[5:0];
            OP_SHR: return $signed(a) >>> b[5:0];
            OP_DIV: begin
                if (b == 0) begin
                    note_error(ST_DIVZ);
                    return '0;
                end
                ma = a[63] ? -a : a;
                mb = b[63] ? -b : b;
                q = ma / mb;
                return (a[63] != b[63]) ? -q : q;
            end
            default: return '0;
        endcase
    endfunction

    function automatic void reduce_top();
        logic [63:0] a, b;
        t_op op;
        b = pop_val();
        a = pop_val();
        op = ops[nops - 1];
        nops--;
        push_val(arith(a, b, op));
    endfunction

    function automatic void operator_in(t_op op);
        while (nops > 0 && binding(ops[nops - 1]) >= binding(op)) reduce_top();
        push_op(op);
    endfunction

    function automatic int digit_val(t_mode m, logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            if (m == MODE_BIN && c > "1") return -1;
            return int'(c - "0");
        end
        if (m == MODE_HEX) begin
            if (c >= "a" && c <= "f") return int'(c - "a") + 10;
            if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        end
        return -1;
    endfunction

    function automatic void drop_literal();
        lit_mode = MODE_NONE;
        lit_acc = '0;
        lit_neg = 0;
        lit_digits = 0;
    endfunction

    function automatic void close_literal();
        logic [31:0] v;
        if (lit_mode == MODE_NONE) return;
        v = lit_neg ? -lit_acc : lit_acc;
        push_val({{32{v[31]}}, v});
        drop_literal();
    endfunction

    // Decodes one character with its lookahead; returns 1 if the lookahead was consumed.
    function automatic bit decode(logic [7:0] c, logic [7:0] nx);
        t_mode m;
        int d;
        m = (armed != MODE_NONE) ? armed : MODE_DEC;
        armed = MODE_NONE;
        if (c == "0" && (nx == "x" || nx == "b")) begin
            // A sign with no digits yet before a prefix was really a minus operator.
            if (lit_mode != MODE_NONE && !lit_digits) begin
                drop_literal();
                operator_in(OP_SUB);
            end else begin
                close_literal();
            end
            armed = (nx == "x") ? MODE_HEX : MODE_BIN;
            return 1;
        end
        if ((c == "<" && nx == "<") || (c == ">" && nx == ">")) begin
            close_literal();
            operator_in(c == "<" ? OP_SHL : OP_SHR);
            return 1;
        end
        if (lit_mode != MODE_NONE) begin
            d = digit_val(lit_mode, c);
            if (d >= 0) begin
                case (lit_mode)
                    MODE_HEX: lit_acc = lit_acc * 16 + d;
                    MODE_BIN: lit_acc = lit_acc * 2 + d;
                    default:  lit_acc = lit_acc * 10 + d;
                endcase
                lit_digits = 1;
                return 0;
            end
            close_literal();
        end
        d = digit_val(m, c);
        if (d >= 0) begin
            lit_mode = m;
            lit_acc = d;
            lit_neg = 0;
            lit_digits = 1;
            return 0;
        end
        case (c)
            "-": begin
                if (digit_val(m, nx) >= 0) begin
                    lit_mode = m;
                    lit_acc = '0;
                    lit_neg = 1;
                    lit_digits = 0;
                end else begin
                    operator_in(OP_SUB);
                end
            end
            "+": operator_in(OP_ADD);
            "*": operator_in(OP_MUL);
            "/": operator_in(OP_DIV);
            "&": operator_in(OP_AND);
            "|": operator_in(OP_OR);
            "^": operator_in(OP_XOR);
            "(": push_op(OP_LPAREN);
            ")": begin
                while (nops > 0 && ops[nops - 1] != OP_LPAREN) reduce_top();
                if (nops > 0) nops--;
            end
            default: ;
        endcase
        return 0;
    endfunction

    function automatic void take_request(logic [7:0] c, bit last);
        bit used;
        t_answer ans;
        used = 0;
        if (held_valid) begin
            used = decode(held_char, c);
            held_valid = 0;
        end
        if (!used) begin
            if (last) void'(decode(c, " "));
            else begin
                held_valid = 1;
                held_char = c;
            end
        end
        if (!last) return;
        close_literal();
        while (nops > 0) begin
            if (ops[nops - 1] == OP_LPAREN) nops--;
            else reduce_top();
        end
        ans.value = pop_val();
        ans.status = err;
        answers_due.push_back(ans);
        clear_model();
    endfunction

    initial begin
        o_failures = 0;
        clear_model();
    end

    assign o_outstanding = answers_due.size();

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n) begin
            if (start && !busy) take_request(i_character, i_end_of_expression);
            if (o_strobe) begin
                if (answers_due.size() == 0) begin
                    o_failures <= o_failures + 1;
                    if (o_failures < 10)
                        $display("unexpected result value=%h status=%0d", o_value, o_status);
                end else begin
                    want = answers_due.pop_front();
                    if (want.value !== o_value || want.status !== o_status) begin
                        o_failures <= o_failures + 1;
                        if (o_failures < 10)
                            $display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                                     want.value, want.status, o_value, o_status);
                    end
                end
            end
        end
    end

endmodule

@@ sim/infix_integer_expression_evaluator_tb.sv @@
// ----------------------------------------------------------------------------
// infix_integer_expression_evaluator_tb
// Feeds directed and random infix expressions to the evaluator one character
// per request, with random gaps, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module infix_integer_expression_evaluator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [7:0]  i_character = '0;
    logic        i_end_of_expression = 0;
    logic        o_strobe;
    logic [63:0] o_value;
    logic [1:0]  o_status;
    int          failures;
    int          outstanding;
    int          chars_sent = 0;

    infix_integer_expression_evaluator dut (
        .i_clk, .i_rst_n, .start, .busy, .i_character, .i_end_of_expression,
        .o_strobe, .o_value, .o_status
    );

    infix_integer_expression_evaluator_checker checker_i (
        .i_clk, .i_rst_n, .start, .busy, .i_character, .i_end_of_expression,
        .o_strobe, .o_value, .o_status, .o_failures(failures),
        .o_outstanding(outstanding)
    );

    always #5 i_clk = ~i_clk;

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sends one request and waits for it to be taken; may then idle for a while.
    task automatic send_char(input logic [7:0] c, input bit last);
        int gap;
        i_character <= c;
        i_end_of_expression <= last;
        start <= 1;
        do @(posedge i_clk); while (busy);
        chars_sent++;
        gap = gap_length();
        if (gap > 0) begin
            start <= 0;
            i_character <= $urandom_range(0, 255);
            i_end_of_expression <= $urandom_range(0, 1);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_expr(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    function automatic string hex_digit();
        string pool;
        pool = "0123456789abcdefABCDEF";
        return $sformatf("%c", pool[$urandom_range(0, pool.len() - 1)]);
    endfunction

    function automatic string literal_text();
        string s;
        int n;
        s = ($urandom_range(0, 3) == 0) ? "-" : "";
        case ($urandom_range(0, 5))
            0: s = {s, "0x"};
            1: s = {s, "0b"};
            default: ;
        endcase
        if (s.len() > 0 && s[s.len() - 1] == "x") begin
            n = $urandom_range(1, 9);
            repeat (n) s = {s, hex_digit()};
        end else if (s.len() > 0 && s[s.len() - 1] == "b") begin
            n = $urandom_range(1, 33);
            repeat (n) s = {s, $sformatf("%0d", $urandom_range(0, 1))};
        end else begin
            case ($urandom_range(0, 3))
                0: s = {s, $sformatf("%0d", $urandom_range(0, 9))};
                1: s = {s, $sformatf("%0d", $urandom())};
                2: s = {s, $sformatf("%0d%0d", $urandom_range(1, 9), $urandom())};
                default: s = {s, $sformatf("%0d", $urandom_range(0, 999))};
            endcase
        end
        return s;
    endfunction

    function automatic string operator_text();
        case ($urandom_range(0, 9))
            0: return "+";
            1: return "-";
            2: return "*";
            3: return "/";
            4: return "&";
            5: return "|";
            6: return "^";
            7: return "<<";
            8: return ">>";
            default: return ($urandom_range(0, 1) != 0) ? "/0*" : "-";
        endcase
    endfunction

    function automatic string spacing();
        case ($urandom_range(0, 9))
            0: return " ";
            1: return $sformatf("%c", $urandom_range(0, 255));
            default: return "";
        endcase
    endfunction

    // Mostly well-formed expressions with random content; a few are broken.
    function automatic string random_expr();
        string s;
        int terms, depth;
        s = "";
        depth = 0;
        terms = $urandom_range(1, 6);
        for (int t = 0; t < terms; t++) begin
            while ($urandom_range(0, 4) == 0) begin
                s = {s, "("};
                depth++;
            end
            s = {s, spacing(), literal_text(), spacing()};
            while (depth > 0 && $urandom_range(0, 2) == 0) begin
                s = {s, ")"};
                depth--;
            end
            if (t < terms - 1) s = {s, operator_text(), spacing()};
        end
        if ($urandom_range(0, 1) != 0) repeat (depth) s = {s, ")"};
        if ($urandom_range(0, 14) == 0) s = {s, operator_text()};
        if ($urandom_range(0, 14) == 0) s = {")", s};
        return s;
    endfunction

    initial begin
        string s;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_expr("0xFFFFFFFF+4294967296");
        send_expr("-0b1010*0x7fffffff");
        send_expr("5-0x3^1");
        send_expr("1<<63/-1");
        send_expr("-8>>65");
        send_expr("7/0");
        send_expr("+");
        send_expr("0bz)(2");
        send_expr("(1+2");
        send_expr("9");

        // Let the block drain completely once before the random part.
        start <= 0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);

        while (chars_sent < 1050) begin
            case ($urandom_range(0, 39))
                0: begin
                    s = "";
                    repeat (66) s = {s, "1 "};
                    send_expr(s);
                end
                1: begin
                    s = "";
                    repeat (65) s = {s, "("};
                    send_expr({s, "3"});
                end
                2: begin
                    s = "";
                    repeat ($urandom_range(1, 8)) s = {s, $sformatf("%c", $urandom_range(0, 255))};
                    send_expr(s);
                end
                default: send_expr(random_expr());
            endcase
        end

        start <= 0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (failures == 0) $display("infix_integer_expression_evaluator test passed");
        else $display("infix_integer_expression_evaluator test failed");
        $finish;
    end

    initial begin
        #8ms;
        $display("infix_integer_expression_evaluator test failed");
        $finish;
    end

endmodule
